FILE: rtl/mspt_pkg.sv
// Shared types, constants and helpers for the multi-slot periodic timer.
// Used by mspt_store and multi_slot_periodic_timer; depends on nothing.
package mspt_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int COUNT_BITS = 24;
	localparam int SLOT_BITS  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int SLOT_W     = 4;
	localparam int PERIOD_W   = 24;
	localparam int ELAPSED_W  = 16;
	localparam int SAT_W      = (PERIOD_W > COUNT_BITS) ? PERIOD_W : COUNT_BITS;
	localparam int SUB_W      = (ELAPSED_W > COUNT_BITS) ? ELAPSED_W : COUNT_BITS;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [SLOT_BITS-1:0]  slot_idx_t;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_CREATE = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_CREATED  = 3'd0,
		KIND_FULL     = 3'd1,
		KIND_DELETED  = 3'd2,
		KIND_INVALID  = 3'd3,
		KIND_EXPIRY   = 3'd4,
		KIND_TICKDONE = 3'd5,
		KIND_CLEARED  = 3'd6
	} kind_t;

	// write port of the slot store
	typedef struct packed {
		logic      rem_we;
		logic      per_we;
		slot_idx_t addr;
		count_t    rem_data;
		count_t    per_data;
	} store_wr_t;

	// clamp a requested period to the count width
	function automatic count_t sat_period(input logic [PERIOD_W-1:0] p);
		logic [SAT_W-1:0] pw;
		pw = SAT_W'(p);
		if ((pw >> COUNT_BITS) != '0)
			return '1;
		return COUNT_BITS'(pw);
	endfunction

endpackage

FILE: rtl/mspt_store.sv
// Slot store: remaining counts and reload periods, one write port and one
// registered read port each. Depends on mspt_pkg.
module mspt_store (
	input  logic                clk,
	input  mspt_pkg::slot_idx_t rd_addr,
	input  mspt_pkg::store_wr_t wr,
	output mspt_pkg::count_t    rem_rdata,
	output mspt_pkg::count_t    per_rdata
);
	import mspt_pkg::*;

	count_t rem_mem_q [NUM_TIMERS];
	count_t per_mem_q [NUM_TIMERS];
	count_t rem_rd_q;
	count_t per_rd_q;

	always_ff @(posedge clk) begin
		if (wr.rem_we) begin
			rem_mem_q[wr.addr] <= wr.rem_data;
		end
		if (wr.per_we) begin
			per_mem_q[wr.addr] <= wr.per_data;
		end
		rem_rd_q <= rem_mem_q[rd_addr];
		per_rd_q <= per_mem_q[rd_addr];
	end

	assign rem_rdata = rem_rd_q;
	assign per_rdata = per_rd_q;

endmodule

FILE: rtl/multi_slot_periodic_timer.sv
// Multi-slot periodic timer: a table of NUM_TIMERS timers driven by command words.
// Tick: the slots pass one per cycle through the shared subtract/compare unit, stalling
// while an expiry waits on the output register, then the done word is loaded; create
// scans one live bit per cycle for the lowest free slot; delete and clear go straight
// to the response. Words wait on m_tready; s_tready rises with the load of the final word.
// arst_n clears the live bits, the sequencer and the output valid; counts are never cleared.
module multi_slot_periodic_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [3:0] slot, [27:4] period_ms, [43:28] elapsed_ms, rest 0
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [3:0] which_slot, rest 0
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast    // last word caused by this command
);
	import mspt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_TICK,
		ST_DONE,
		ST_RESP
	} state_t;

	state_t                  state_q;
	slot_idx_t               idx_q;
	logic [NUM_TIMERS-1:0]   live_q;
	count_t                  period_q;
	logic [ELAPSED_W-1:0]    elapsed_q;
	kind_t                   res_kind_q;
	logic [SLOT_W-1:0]       res_slot_q;
	logic                    m_tvalid_q;
	kind_t                   out_kind_q;
	logic [SLOT_W-1:0]       out_slot_q;
	logic                    out_last_q;

	// input word fields
	cmd_t                    in_cmd;
	logic [SLOT_W-1:0]       in_slot;
	logic [PERIOD_W-1:0]     in_period;
	logic [ELAPSED_W-1:0]    in_elapsed;
	slot_idx_t               in_idx;
	logic                    accept;
	logic                    del_ok;

	// shared unit and store
	slot_idx_t               rd_addr;
	store_wr_t               wr;
	count_t                  rem_rd;
	count_t                  per_rd;
	logic [SUB_W-1:0]        rem_w;
	logic [SUB_W-1:0]        ela_w;
	count_t                  dec_r;
	logic                    idx_last;
	logic                    out_free;
	logic                    out_load;
	logic                    expire;
	logic                    can_go;

	assign in_cmd     = cmd_t'(s_tuser);
	assign in_slot    = s_tdata[3:0];
	assign in_period  = s_tdata[27:4];
	assign in_elapsed = s_tdata[43:28];
	assign in_idx     = SLOT_BITS'(in_slot);
	assign accept     = s_tvalid && s_tready;
	assign del_ok     = (32'(in_slot) < 32'(NUM_TIMERS)) && live_q[in_idx];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_slot_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign idx_last = (idx_q == SLOT_BITS'(NUM_TIMERS - 1));

	// saturating decrement of the slot under the cursor
	assign rem_w  = SUB_W'(rem_rd);
	assign ela_w  = SUB_W'(elapsed_q);
	assign dec_r  = (rem_w > ela_w) ? COUNT_BITS'(rem_w - ela_w) : '0;
	assign expire = live_q[idx_q] && (dec_r == '0);
	// an expiry needs the output register; otherwise the slot never waits
	assign can_go = !expire || out_free;

	// a new word enters the output register this cycle
	assign out_load = ((state_q == ST_TICK) && can_go && expire)
		|| (((state_q == ST_DONE) || (state_q == ST_RESP)) && out_free);

	// Read address: the store read is registered, so it is addressed to the slot worked
	// on next (the same slot while stalled). Idle reads slot 0 so a tick starts on the accept edge.
	always_comb begin
		rd_addr = '0;
		if (state_q == ST_TICK) begin
			if (!can_go)
				rd_addr = idx_q;
			else if (!idx_last)
				rd_addr = SLOT_BITS'(idx_q + 1'b1);
		end
	end

	always_comb begin
		wr          = '0;
		wr.addr     = idx_q;
		wr.per_data = period_q;
		wr.rem_data = period_q;
		case (state_q)
			ST_FIND: begin
				// load both period and count into the first free slot
				wr.rem_we = !live_q[idx_q];
				wr.per_we = !live_q[idx_q];
			end
			ST_TICK: begin
				// write back the lowered count, or reload on expiry
				wr.rem_we   = live_q[idx_q] && can_go;
				wr.rem_data = expire ? per_rd : dec_r;
			end
			default: begin
				wr.rem_we = 1'b0;
			end
		endcase
	end

	mspt_store u_store (
		.clk      (clk),
		.rd_addr  (rd_addr),
		.wr       (wr),
		.rem_rdata(rem_rd),
		.per_rdata(per_rd)
	);

	// Payload capture: hold the command operands for the sequencer.
	always_ff @(posedge clk) begin
		if (accept) begin
			period_q  <= sat_period(in_period);
			elapsed_q <= in_elapsed;
		end
	end

	// Sequencer, live bits and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			live_q     <= '0;
			res_kind_q <= KIND_CREATED;
			res_slot_q <= '0;
			m_tvalid_q <= 1'b0;
			out_kind_q <= KIND_CREATED;
			out_slot_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			// drop the output word once taken, unless a new one loads below
			if (m_tready && !out_load)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						case (in_cmd)
							CMD_TICK: begin
								state_q <= ST_TICK;
							end
							CMD_CREATE: begin
								state_q <= ST_FIND;
							end
							CMD_DELETE: begin
								if (del_ok) begin
									live_q[in_idx] <= 1'b0;
									res_kind_q     <= KIND_DELETED;
									res_slot_q     <= in_slot;
								end else begin
									res_kind_q <= KIND_INVALID;
									res_slot_q <= '0;
								end
								state_q <= ST_RESP;
							end
							CMD_CLEAR: begin
								live_q     <= '0;
								res_kind_q <= KIND_CLEARED;
								res_slot_q <= '0;
								state_q    <= ST_RESP;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end

				ST_FIND: begin
					// scan one live bit per cycle for the lowest free slot
					if (!live_q[idx_q]) begin
						live_q[idx_q] <= 1'b1;
						res_kind_q    <= KIND_CREATED;
						res_slot_q    <= SLOT_W'(idx_q);
						state_q       <= ST_RESP;
						idx_q         <= '0;
					end else if (idx_last) begin
						res_kind_q <= KIND_FULL;
						res_slot_q <= '0;
						state_q    <= ST_RESP;
						idx_q      <= '0;
					end else begin
						idx_q <= SLOT_BITS'(idx_q + 1'b1);
					end
				end

				ST_TICK: begin
					// advance one slot per cycle; stall only on a blocked expiry
					if (can_go) begin
						if (expire) begin
							m_tvalid_q <= 1'b1;
							out_kind_q <= KIND_EXPIRY;
							out_slot_q <= SLOT_W'(idx_q);
							out_last_q <= 1'b0;
						end
						if (idx_last) begin
							idx_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							idx_q <= SLOT_BITS'(idx_q + 1'b1);
						end
					end
				end

				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						out_kind_q <= KIND_TICKDONE;
						out_slot_q <= '0;
						out_last_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end

				ST_RESP: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						out_kind_q <= res_kind_q;
						out_slot_q <= res_slot_q;
						out_last_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// an accepted command always keeps the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input accepted again right after a command");

	// expiries are never the final word of a tick
	a_expiry_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_EXPIRY) |-> !m_tlast)
		else $error("expiry word marked last");

	// clear frees every slot
	a_clear_frees_all: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == CMD_CLEAR) |=> (live_q == '0))
		else $error("slot still live after clear");

	// a tick walk never changes which slots are live
	a_tick_keeps_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK) |=> $stable(live_q))
		else $error("live bits changed during tick");

endmodule
